/* sv/bsi_pkg.sv */
// Shared constants and types for the bit set store with iterator.
package bsi_pkg;

  // Store geometry: a word holds 2**WORD_LOG2 bits.
  localparam int WORD_LOG2  = 6;
  localparam int WORD_BITS  = 1 << WORD_LOG2;
  localparam int WORD_DEPTH = 64;
  localparam int ADDR_W     = $clog2(WORD_DEPTH);
  localparam int CNT_W      = $clog2(WORD_DEPTH + 1);
  localparam int POS_W      = CNT_W + WORD_LOG2;

  // Field widths of the stream words.
  localparam int REQ_W   = 3;
  localparam int BI_W    = 12;
  localparam int WI_W    = 6;
  localparam int DATA_W  = 64;
  localparam int WIDX_W  = BI_W - WORD_LOG2;
  localparam int CMP_W   = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;

  // Leading-one search splits a word into byte groups.
  localparam int GRP_BITS = 8;
  localparam int GRP_CNT  = WORD_BITS / GRP_BITS;
  localparam int LEAD_W   = $clog2(GRP_BITS);

  typedef enum logic [REQ_W-1:0] {
    REQ_TEST       = 3'd0,
    REQ_SET        = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_UNION      = 3'd3,
    REQ_ITER_START = 3'd4,
    REQ_ITER_NEXT  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_DONE
  } state_t;

  // Result of the first-set-bit search over one word.
  typedef struct packed {
    logic                 found;
    logic [WORD_LOG2-1:0] idx;
  } find_res_t;

endpackage

/* sv/bsi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read on the same edge; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bsi_find.sv */
// Two-stage first-set-bit search over one word (bit 0 is the MSB).
module bsi_find (
  input  logic                          clk,
  input  logic [bsi_pkg::WORD_BITS-1:0] word,
  output bsi_pkg::find_res_t            res
);
  import bsi_pkg::*;

  logic [GRP_CNT-1:0] grp_nz_r;
  logic [LEAD_W-1:0]  grp_lead_r [GRP_CNT];

  // Stage one: per byte group, flag nonzero and locate its first set bit.
  always_ff @(posedge clk) begin
    for (int g = 0; g < GRP_CNT; g++) begin
      logic [LEAD_W-1:0] lead;
      logic              nz;
      lead = '0;
      nz   = 1'b0;
      for (int k = GRP_BITS - 1; k >= 0; k--) begin
        if (word[WORD_BITS-1-(g*GRP_BITS+k)]) begin
          lead = LEAD_W'(k);
          nz   = 1'b1;
        end
      end
      grp_nz_r[g]   <= nz;
      grp_lead_r[g] <= lead;
    end
  end

  // Stage two: pick the first nonzero group.
  always_comb begin
    res.found = 1'b0;
    res.idx   = '0;
    for (int g = GRP_CNT - 1; g >= 0; g--) begin
      if (grp_nz_r[g]) begin
        res.found = 1'b1;
        res.idx   = WORD_LOG2'(g * GRP_BITS + int'(grp_lead_r[g]));
      end
    end
  end

endmodule

/* sv/bit_set_store_with_iterator_top.sv */
// Top level of the bit set store with a forward iterator over set bits.
//
// Usage: requests arrive as words on the in_ stream; every request yields
// exactly one result word on the out_ stream, in order. Requests are test,
// set, remove, union of a source word, iterator start and iterator next.
// The store lives in one RAM of WORD_DEPTH words; set, remove and union
// do at most one read-modify-write of that RAM, and test only reads it.
// Iterator start goes straight to its result; test, set, remove, union
// and unknown codes take one RAM read and one execute step; iterator next
// scans word by word, each word taking one RAM read and one search step
// (the registered RAM read, then the two-stage leading-one search), and
// yields its result without a scan when the iterator already sits at its
// limit. One request is in flight at a time; the next one can be taken in
// the cycle after the previous result is loaded into the output
// register.
// Reset (rst_n low, synchronous) clears the word count, the iterator and
// the per-word valid bits, so every word reads as zero afterwards; no
// clearing pass is needed. When the receiver holds out_tready low, the
// output word is held and a further result waits in the final state.
module bit_set_store_with_iterator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // req_type[2:0], bit_index[14:3], word_index[20:15], word_data[84:21]
  input  logic [bsi_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], bit_position[12:1], used_words[19:13]
  output logic [bsi_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bsi_pkg::*;

  // Input field unpacking.
  logic [REQ_W-1:0]  in_req;
  logic [BI_W-1:0]   in_bit_index;
  logic [WI_W-1:0]   in_word_index;
  logic [DATA_W-1:0] in_word_data;

  assign in_req        = in_tdata[2:0];
  assign in_bit_index  = in_tdata[14:3];
  assign in_word_index = in_tdata[20:15];
  assign in_word_data  = in_tdata[84:21];

  // Control and state registers.
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [POS_W-1:0]     iter_pos_r, iter_pos_nxt;
  logic [POS_W-1:0]     iter_lim_r, iter_lim_nxt;
  logic [WORD_DEPTH-1:0] valid_r;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic                 rd_issue;

  // Latched request.
  logic [REQ_W-1:0]     req_r;
  logic [BI_W-1:0]      bit_index_r;
  logic [WI_W-1:0]      word_index_r;
  logic [WORD_BITS-1:0] word_data_r;

  // Pending result.
  logic                 res_hit_r, res_hit_nxt;
  logic [BI_W-1:0]      res_pos_r, res_pos_nxt;

  // Output register.
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [BI_W-1:0]      out_pos_r;
  logic [CNT_W-1:0]     out_used_r;
  logic                 out_load;

  // RAM port signals.
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] scan_word;
  find_res_t            fres;

  // Derived request fields.
  logic [WIDX_W-1:0]    tgt_word;
  logic [WORD_LOG2-1:0] sub;
  logic [WORD_BITS-1:0] weight;
  logic [CNT_W-1:0]     iter_word;
  logic [WORD_LOG2-1:0] iter_sub;
  logic [CNT_W-1:0]     iter_word_inc;
  logic [POS_W-1:0]     next_word_pos;
  logic [POS_W-1:0]     found_pos;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_used_r, out_pos_r, out_hit_r});
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign tgt_word      = bit_index_r[BI_W-1:WORD_LOG2];
  assign sub           = bit_index_r[WORD_LOG2-1:0];
  assign weight        = WORD_BITS'(1) << ~sub;
  assign iter_word     = iter_pos_r[POS_W-1:WORD_LOG2];
  assign iter_sub      = iter_pos_r[WORD_LOG2-1:0];
  assign iter_word_inc = iter_word + CNT_W'(1);
  assign next_word_pos = {iter_word_inc, {WORD_LOG2{1'b0}}};
  assign found_pos     = {iter_word, fres.idx};

  // Words never written read as zero.
  assign word_in   = valid_r[rd_addr_r] ? ram_rdata : '0;
  assign scan_word = word_in & ({WORD_BITS{1'b1}} >> iter_sub);

  bsi_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(rd_addr_r),
    .wdata(ram_wdata),
    .raddr(rd_addr_nxt),
    .rdata(ram_rdata)
  );

  bsi_find u_find (
    .clk (clk),
    .word(scan_word),
    .res (fres)
  );

  // Sequence one request: read, modify, write back or scan.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    iter_pos_nxt = iter_pos_r;
    iter_lim_nxt = iter_lim_r;
    rd_addr_nxt  = rd_addr_r;
    rd_issue     = 1'b0;
    res_hit_nxt  = res_hit_r;
    res_pos_nxt  = res_pos_r;
    ram_we       = 1'b0;
    ram_wdata    = word_in;
    unique case (state_r)
      S_IDLE: begin
        // Pick the read address from the incoming word, or from the iterator for iterator next.
        unique case (in_req)
          REQ_UNION:     rd_addr_nxt = in_word_index[ADDR_W-1:0];
          REQ_ITER_NEXT: rd_addr_nxt = iter_word[ADDR_W-1:0];
          default:       rd_addr_nxt = in_bit_index[WORD_LOG2 +: ADDR_W];
        endcase
        if (in_tvalid) begin
          rd_issue    = 1'b1;
          res_hit_nxt = 1'b0;
          res_pos_nxt = '0;
          if (in_req == REQ_ITER_START) begin
            iter_pos_nxt = '0;
            iter_lim_nxt = POS_W'(count_r) << WORD_LOG2;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (req_r)
          REQ_TEST: begin
            res_hit_nxt = word_in[~sub] && (CMP_W'(tgt_word) < CMP_W'(count_r));
          end
          REQ_SET: begin
            if (CMP_W'(tgt_word) < CMP_W'(WORD_DEPTH)) begin
              ram_we    = 1'b1;
              ram_wdata = word_in | weight;
              if (CMP_W'(tgt_word) >= CMP_W'(count_r)) begin
                count_nxt = CNT_W'(tgt_word) + CNT_W'(1);
              end
            end
          end
          REQ_REMOVE: begin
            if (CMP_W'(tgt_word) < CMP_W'(count_r) &&
                CMP_W'(tgt_word) < CMP_W'(WORD_DEPTH)) begin
              ram_we    = 1'b1;
              ram_wdata = word_in & ~weight;
            end
          end
          REQ_UNION: begin
            if (CMP_W'(word_index_r) < CMP_W'(WORD_DEPTH)) begin
              ram_we    = 1'b1;
              ram_wdata = word_in | word_data_r;
              if (CMP_W'(word_index_r) >= CMP_W'(count_r)) begin
                count_nxt = CNT_W'(word_index_r) + CNT_W'(1);
              end
            end
          end
          REQ_ITER_NEXT: begin
            // Scan only while below the frozen limit.
            if (iter_pos_r < iter_lim_r) begin
              state_nxt = S_FIND;
            end
          end
          default: begin
          end
        endcase
      end
      S_FIND: begin
        if (fres.found) begin
          res_hit_nxt  = 1'b1;
          res_pos_nxt  = BI_W'(found_pos);
          iter_pos_nxt = found_pos + POS_W'(1);
          state_nxt    = S_DONE;
        end else if (next_word_pos >= iter_lim_r) begin
          iter_pos_nxt = iter_lim_r;
          state_nxt    = S_DONE;
        end else begin
          // Advance to the start of the next word and read it.
          iter_pos_nxt = next_word_pos;
          rd_addr_nxt  = iter_word_inc[ADDR_W-1:0];
          rd_issue     = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iter_pos_r  <= '0;
      iter_lim_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      iter_pos_r <= iter_pos_nxt;
      iter_lim_r <= iter_lim_nxt;
      if (ram_we) begin
        valid_r[rd_addr_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_addr_r <= rd_addr_nxt;
    end
    if (in_tvalid && in_tready) begin
      req_r        <= in_req;
      bit_index_r  <= in_bit_index;
      word_index_r <= in_word_index;
      word_data_r  <= in_word_data[WORD_BITS-1:0];
    end
    res_hit_r <= res_hit_nxt;
    res_pos_r <= res_pos_nxt;
    if (out_load) begin
      out_hit_r  <= res_hit_r;
      out_pos_r  <= res_pos_r;
      out_used_r <= count_r;
    end
  end

endmodule
